[hdl/u8dec_pkg.sv]
// Shared widths, sequence-length and surrogate constants and status codes for the UTF-8 decoder.
// No dependencies; imported by the interfaces and the core.
package u8dec_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int LEN_W  = 3;
  localparam int STAT_W = 2;
  localparam int PEND_W = 2;

  // Status codes carried on the result word
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_LEAD  = 2'd1;
  localparam logic [STAT_W-1:0] ST_SURROGATE = 2'd2;

  // Sequence lengths
  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

  // Surrogates D800..DFFF share the top ten bits of a 21-bit code point
  localparam logic [9:0] SURR_TOP = 10'h01B;

endpackage

[hdl/u8dec_if.sv]
// Valid/ready channel interfaces: raw bytes in, decoded code points out.
// Depends on u8dec_pkg.
interface u8dec_byte_if import u8dec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8dec_cp_if import u8dec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CP_W-1:0]   code_point;
  logic [LEN_W-1:0]  seq_length;
  logic [STAT_W-1:0] status;

  modport source (output valid, output code_point, output seq_length, output status,
                  input ready);
  modport sink   (input valid, input code_point, input seq_length, input status,
                  output ready);
endinterface

[hdl/utf8_codepoint_decoder_core.sv]
// UTF-8 decoder core: byte stream in, one code point word per complete character or bad lead.
// Depends on u8dec_pkg and the channel interfaces in u8dec_if.sv.
//
// Usage:
//   byte_chan carries one raw byte per word; cp_chan carries code_point,
//   seq_length and status. Both use valid/ready, a word moving on a rising
//   edge with both high.
//   One byte is taken every clock unless the stall below holds it. A byte
//   lands in the input register, is decoded there against the open-sequence
//   state and its result, if it closes a character or is a bad lead, sits
//   in the result register; a word passes the input register and then the
//   result register before it can move on cp_chan.
//   Lead bytes that open a sequence and non-final following bytes give no word.
//   Following bytes are not checked for the 10xxxxxx form; overlong forms pass.
//   Reset (rst, synchronous) drops any open sequence and empties both registers.
//   When cp_chan stalls, the result word holds; the input register still
//   takes bytes, and byte_chan.ready drops only when both are full
//   and the held byte would produce a word.
module utf8_codepoint_decoder_core import u8dec_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  u8dec_byte_if.sink   byte_chan,
  u8dec_cp_if.source   cp_chan
);

  // Input register
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;

  // Sequence state
  logic [PEND_W-1:0] pending, pending_next;
  logic [CP_W-1:0]   accum, accum_next;
  logic [LEN_W-1:0]  seq_total, seq_total_next;

  // Result register
  logic              out_valid;
  logic [CP_W-1:0]   out_cp;
  logic [LEN_W-1:0]  out_len;
  logic [STAT_W-1:0] out_stat;

  logic              emit;
  logic [CP_W-1:0]   emit_cp;
  logic [LEN_W-1:0]  emit_len;
  logic [STAT_W-1:0] emit_stat;
  logic [CP_W-1:0]   shifted;
  logic              out_free;
  logic              s1_take;

  assign out_free = !out_valid || cp_chan.ready;
  // A byte that yields no word never waits on the output side
  assign s1_take  = s1_valid && (out_free || !emit);
  assign byte_chan.ready = !s1_valid || s1_take;

  assign shifted = {accum[CP_W-7:0], s1_byte[5:0]};

  always_comb begin
    emit           = 1'b0;
    emit_cp        = '0;
    emit_len       = LEN_NONE;
    emit_stat      = ST_OK;
    pending_next   = pending;
    accum_next     = accum;
    seq_total_next = seq_total;
    if (pending == '0) begin
      if (!s1_byte[7]) begin
        emit     = 1'b1;
        emit_cp  = {{(CP_W-BYTE_W){1'b0}}, s1_byte};
        emit_len = LEN_ONE;
      end else if (s1_byte[7:6] == 2'b10 || s1_byte[7:3] == 5'b11111) begin
        emit      = 1'b1;
        emit_stat = ST_BAD_LEAD;
      end else if (!s1_byte[5]) begin
        accum_next     = {{(CP_W-5){1'b0}}, s1_byte[4:0]};
        pending_next   = 2'd1;
        seq_total_next = LEN_TWO;
      end else if (!s1_byte[4]) begin
        accum_next     = {{(CP_W-4){1'b0}}, s1_byte[3:0]};
        pending_next   = 2'd2;
        seq_total_next = LEN_THREE;
      end else begin
        accum_next     = {{(CP_W-3){1'b0}}, s1_byte[2:0]};
        pending_next   = 2'd3;
        seq_total_next = LEN_FOUR;
      end
    end else begin
      accum_next   = shifted;
      pending_next = pending - 2'd1;
      if (pending == 2'd1) begin
        emit           = 1'b1;
        emit_len       = seq_total;
        accum_next     = '0;
        seq_total_next = LEN_NONE;
        if (seq_total == LEN_THREE && shifted[CP_W-1:11] == SURR_TOP) begin
          emit_stat = ST_SURROGATE;
        end else begin
          emit_cp = shifted;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      pending   <= '0;
      accum     <= '0;
      seq_total <= LEN_NONE;
    end else begin
      if (byte_chan.valid && byte_chan.ready) begin
        s1_valid <= 1'b1;
        s1_byte  <= byte_chan.byte_in;
      end else if (s1_take) begin
        s1_valid <= 1'b0;
      end
      if (s1_take) begin
        pending   <= pending_next;
        accum     <= accum_next;
        seq_total <= seq_total_next;
      end
      if (s1_take && emit) begin
        out_valid <= 1'b1;
        out_cp    <= emit_cp;
        out_len   <= emit_len;
        out_stat  <= emit_stat;
      end else if (cp_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign cp_chan.valid      = out_valid;
  assign cp_chan.code_point = out_cp;
  assign cp_chan.seq_length = out_len;
  assign cp_chan.status     = out_stat;

`ifndef NO_ASSERTIONS
  a_pending_len: assert property (@(posedge clk) disable iff (rst)
    (pending != '0) |-> (seq_total > {1'b0, pending}))
    else $error("open sequence longer than its recorded length");

  a_bad_lead_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stat == ST_BAD_LEAD) |-> (out_cp == '0 && out_len == LEN_NONE))
    else $error("invalid lead word carries data");

  a_surr_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stat == ST_SURROGATE) |-> (out_cp == '0 && out_len == LEN_THREE))
    else $error("surrogate word malformed");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && emit && out_valid && !cp_chan.ready) |-> !byte_chan.ready)
    else $error("input taken while result path blocked");
`endif

endmodule
